// ===== rtl/core/wdc_pkg.sv =====
package wdc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_TARE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_TARE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STABILITY_TOL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TOL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_TOL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_TOL      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_PITCH     = 3'd6;

  localparam logic [2:0] ACT_TILT    = 3'd0;
  localparam logic [2:0] ACT_HEADING = 3'd1;
  localparam logic [2:0] ACT_SIDE    = 3'd2;
  localparam logic [2:0] ACT_FRONT   = 3'd3;
  localparam logic [2:0] ACT_ADVANCE = 3'd4;
  localparam logic [2:0] ACT_STOP    = 3'd5;

  localparam logic [3:0] FINAL_TURN = 4'd10;

  localparam logic [6:0] DRIVE_MIN     = 7'd70;
  localparam logic [6:0] DRIVE_MAX     = 7'd110;
  localparam logic [6:0] DRIVE_NEUTRAL = 7'd90;
  localparam logic [6:0] DRIVE_TILT_L  = 7'd100;
  localparam logic [6:0] DRIVE_TILT_R  = 7'd80;

  typedef struct packed {
    logic [8:0]  heading_deg;
    logic [8:0]  tilt_deg;
    logic [15:0] front_mm;
    logic [15:0] left_mm;
  } wdc_in_t;

  typedef struct packed {
    logic       drive_valid;
    logic [6:0] left_drive;
    logic [6:0] right_drive;
    logic [2:0] action_code;
    logic       goal_done;
  } wdc_out_t;

endpackage

// ===== rtl/core/waypoint_drive_correction.sv =====
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_data (wdc_in_t)
// out_    | output    | out_valid/out_stall| out_data (wdc_out_t)
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle is accepted unless a stalled result holds the flow; the single
// compute stage lies between the input register and the result register, which offers it.
// Synchronous active-low reset clears the turn counter, the done flag and all valids,
// and loads the register defaults. A stalled result register holds its item while
// the input register still takes one more item; the configuration port is always ready.
module waypoint_drive_correction (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  wdc_pkg::wdc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output wdc_pkg::wdc_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wdc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wdc_pkg::*;

  logic [8:0] heading_tare_r;
  logic [8:0] tilt_tare_r;
  logic [8:0] stability_tol_r;
  logic [7:0] angle_tol_r;
  logic [9:0] side_tol_r;
  logic [9:0] front_tol_r;
  logic [9:0] tile_pitch_r;

  logic [3:0] turn_count_r, turn_count_nxt;
  logic       done_flag_r, done_flag_nxt;

  logic       s1_valid_r;
  wdc_in_t    s1_data_r;
  logic       out_valid_r;
  wdc_out_t   out_data_r;
  wdc_out_t   res;
  logic       s1_stall;
  logic       fire;

  logic signed [9:0]  tilt_diff;
  logic [9:0]         tilt_abs;
  logic               tilt_off;
  logic [8:0]         head_tgt;
  logic signed [10:0] ang_err;
  logic [10:0]        ang_abs;
  logic               ang_off;
  logic signed [10:0] head_sum;
  logic [6:0]         head_drive;
  logic [2:0]         front_k;
  logic [4:0]         tc_plus;
  logic [12:0]        front_tgt;
  logic [12:0]        side_tgt;
  logic signed [17:0] front_err;
  logic signed [17:0] side_err;
  logic [17:0]        front_abs;
  logic [17:0]        side_abs;
  logic               front_off;
  logic               side_off;
  logic [6:0]         side_t;
  logic [6:0]         front_t;

  function automatic logic [6:0] dist_scale(input logic signed [17:0] err);
    logic signed [17:0] w;
    logic [10:0]        wc;
    logic [25:0]        prod;
    w = err + 18'sd1000;
    if (w < 18'sd0) begin
      wc = 11'd0;
    end else if (w > 18'sd1240) begin
      wc = 11'd1240;
    end else begin
      wc = w[10:0];
    end
    prod = {15'd0, wc} * 26'd47187;
    return prod[25:19];
  endfunction

  function automatic logic [6:0] clamp_drive(input logic [7:0] v);
    if (v > {1'b0, DRIVE_MAX}) begin
      return DRIVE_MAX;
    end else if (v < {1'b0, DRIVE_MIN}) begin
      return DRIVE_MIN;
    end else begin
      return v[6:0];
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign s1_stall  = out_valid_r && out_stall;
  assign in_stall  = s1_valid_r && s1_stall;
  assign fire      = s1_valid_r && !s1_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    tilt_diff = $signed({1'b0, s1_data_r.tilt_deg}) - $signed({1'b0, tilt_tare_r});
    tilt_abs  = tilt_diff[9] ? 10'(-tilt_diff) : tilt_diff;
    tilt_off  = tilt_abs > {1'b0, stability_tol_r};

    case (turn_count_r[1:0])
      2'd0:    head_tgt = 9'd0;
      2'd1:    head_tgt = 9'd90;
      2'd2:    head_tgt = 9'd180;
      default: head_tgt = 9'd270;
    endcase
    ang_err = $signed({2'b00, s1_data_r.heading_deg}) - $signed({2'b00, heading_tare_r})
              - $signed({2'b00, head_tgt});
    ang_abs = ang_err[10] ? 11'(-ang_err) : ang_err;
    ang_off = ang_abs > {3'b000, angle_tol_r};

    head_sum = ang_err + 11'sd360;
    if (head_sum < 11'sd280) begin
      head_drive = DRIVE_MIN;
    end else if (head_sum >= 11'sd444) begin
      head_drive = DRIVE_MAX;
    end else begin
      head_drive = head_sum[8:2];
    end

    tc_plus   = {1'b0, turn_count_r} + 5'd1;
    front_k   = tc_plus[4:2];
    front_tgt = ({3'b000, tile_pitch_r} * {10'd0, front_k}) + 13'd50;
    side_tgt  = ({3'b000, tile_pitch_r} * {11'd0, turn_count_r[3:2]}) + 13'd100;
    front_err = $signed({2'b00, s1_data_r.front_mm}) - $signed({5'd0, front_tgt});
    side_err  = $signed({2'b00, s1_data_r.left_mm}) - $signed({5'd0, side_tgt});
    front_abs = front_err[17] ? 18'(-front_err) : front_err;
    side_abs  = side_err[17] ? 18'(-side_err) : side_err;
    front_off = front_abs > {8'd0, front_tol_r};
    side_off  = side_abs > {8'd0, side_tol_r};
    side_t    = dist_scale(side_err);
    front_t   = dist_scale(front_err);

    turn_count_nxt  = turn_count_r;
    done_flag_nxt   = done_flag_r;
    res.drive_valid = 1'b1;
    res.left_drive  = DRIVE_NEUTRAL;
    res.right_drive = DRIVE_NEUTRAL;
    res.action_code = ACT_STOP;
    res.goal_done   = done_flag_r;

    if (done_flag_r) begin
      res.action_code = ACT_STOP;
    end else if (tilt_off) begin
      res.left_drive  = DRIVE_TILT_L;
      res.right_drive = DRIVE_TILT_R;
      res.action_code = ACT_TILT;
    end else if (ang_off) begin
      res.left_drive  = head_drive;
      res.right_drive = head_drive;
      res.action_code = ACT_HEADING;
    end else if (side_off) begin
      res.left_drive  = clamp_drive({1'b0, side_t});
      res.right_drive = clamp_drive(8'd175 - {1'b0, side_t});
      res.action_code = ACT_SIDE;
    end else if (front_off) begin
      res.left_drive  = clamp_drive({1'b0, front_t});
      res.right_drive = clamp_drive(8'd180 - {1'b0, front_t});
      res.action_code = ACT_FRONT;
    end else if (turn_count_r != FINAL_TURN) begin
      turn_count_nxt  = turn_count_r + 4'd1;
      res.drive_valid = 1'b0;
      res.action_code = ACT_ADVANCE;
    end else begin
      done_flag_nxt   = 1'b1;
      res.drive_valid = 1'b0;
      res.action_code = ACT_STOP;
      res.goal_done   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_tare_r  <= 9'd0;
      tilt_tare_r     <= 9'd0;
      stability_tol_r <= 9'd200;
      angle_tol_r     <= 8'd5;
      side_tol_r      <= 10'd70;
      front_tol_r     <= 10'd70;
      tile_pitch_r    <= 10'd250;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADING_TARE:  heading_tare_r  <= cfg_data[8:0];
        CFG_TILT_TARE:     tilt_tare_r     <= cfg_data[8:0];
        CFG_STABILITY_TOL: stability_tol_r <= cfg_data[8:0];
        CFG_ANGLE_TOL:     angle_tol_r     <= cfg_data[7:0];
        CFG_SIDE_TOL:      side_tol_r      <= cfg_data;
        CFG_FRONT_TOL:     front_tol_r     <= cfg_data;
        CFG_TILE_PITCH:    tile_pitch_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_count_r <= 4'd0;
      done_flag_r  <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r  <= 1'b1;
        turn_count_r <= turn_count_nxt;
        done_flag_r  <= done_flag_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  // The goal is reported only together with a stop.
  a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.goal_done |-> out_data_r.action_code == ACT_STOP)
    else $error("goal_done without stop action");

  // The done flag never clears outside reset.
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_flag_r |=> done_flag_r)
    else $error("done flag cleared");

  a_turn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    turn_count_r <= FINAL_TURN)
    else $error("turn counter beyond final turn");

  a_no_drive_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.drive_valid |->
      out_data_r.left_drive == DRIVE_NEUTRAL && out_data_r.right_drive == DRIVE_NEUTRAL)
    else $error("drive values not neutral without drive");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.left_drive >= DRIVE_MIN && out_data_r.left_drive <= DRIVE_MAX
      && out_data_r.right_drive >= DRIVE_MIN && out_data_r.right_drive <= DRIVE_MAX)
    else $error("drive value out of range");

  // The input side stalls only behind a full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && s1_valid_r)
    else $error("input stalled without a waiting item");

endmodule
